### rtl/kdop_pkg.sv
`default_nettype none

package kdop_pkg;

   // Default coordinate width; slab bounds carry two more bits.
   localparam int COORD_BITS_DEFAULT = 16;

   // An 18-DOP has nine slab directions: x, y, z, x+y, x+z, y+z, x-y, x-z, y-z.
   localparam int SLAB_COUNT    = 9;
   localparam int MODE_BITS     = 3;
   localparam int SLAB_IDX_BITS = 4;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_CLEAR     = 3'd0,
      MODE_ADD       = 3'd1,
      MODE_SET       = 3'd2,
      MODE_INSIDE    = 3'd3,
      MODE_READ      = 3'd4,
      MODE_INTERSECT = 3'd5,
      MODE_MERGE     = 3'd6
   } mode_type;

   // Command broadcast from the top level to every slab.
   typedef struct packed {
      mode_type mode;
      logic     write_en;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/kdop18_bounding_volume_unit.sv
`default_nettype none

// Channel    Direction  Ports
// request    in         req_valid, req_ready, req_mode, req_x_coord, req_y_coord,
//                       req_z_coord, req_slab_index, req_other_low, req_other_high
// response   out        rsp_valid, rsp_ready, rsp_flag, rsp_result_low, rsp_result_high
//
// A request is captured in the input register and then passes through the nine slab
// units into the response register, which then shows it as a valid response.
// A new request can be taken every cycle while no response is stalled; commands update
// the slabs strictly in order. Reset is synchronous and empties the volume: each slab
// low at its largest value and each high at its smallest. A stalled response holds the
// input register, which still takes one new request while the older response waits.

module kdop18_bounding_volume_unit #(
   parameter int COORD_BITS = kdop_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [kdop_pkg::MODE_BITS-1:0]        req_mode,
   input  wire logic signed [COORD_BITS-1:0]          req_x_coord,
   input  wire logic signed [COORD_BITS-1:0]          req_y_coord,
   input  wire logic signed [COORD_BITS-1:0]          req_z_coord,
   input  wire logic [kdop_pkg::SLAB_IDX_BITS-1:0]    req_slab_index,
   input  wire logic signed [COORD_BITS+1:0]          req_other_low,
   input  wire logic signed [COORD_BITS+1:0]          req_other_high,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_flag,
   output logic signed [COORD_BITS+1:0]               rsp_result_low,
   output logic signed [COORD_BITS+1:0]               rsp_result_high
);
   import kdop_pkg::*;

   // Sums and differences of two coordinates need one more bit than a coordinate; slabs carry two.
   localparam int SLAB_BITS = COORD_BITS + 2;

   // Input register stage.
   logic                            s1_valid_ff;
   mode_type                        s1_mode_ff;
   logic signed [COORD_BITS-1:0]    s1_x_ff;
   logic signed [COORD_BITS-1:0]    s1_y_ff;
   logic signed [COORD_BITS-1:0]    s1_z_ff;
   logic [SLAB_IDX_BITS-1:0]        s1_slab_ff;
   logic signed [SLAB_BITS-1:0]     s1_olo_ff;
   logic signed [SLAB_BITS-1:0]     s1_ohi_ff;

   // Response register stage.
   logic                            rsp_valid_ff;
   logic                            rsp_flag_ff;
   logic signed [SLAB_BITS-1:0]     rsp_low_ff;
   logic signed [SLAB_BITS-1:0]     rsp_high_ff;
   logic                            rsp_flag_in;
   logic signed [SLAB_BITS-1:0]     rsp_low_in;
   logic signed [SLAB_BITS-1:0]     rsp_high_in;

   logic rsp_open;
   logic s1_fire;
   logic req_fire;

   // The response register can load when it is empty or being drained this cycle.
   assign rsp_open  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && rsp_open;
   assign req_ready = !s1_valid_ff || rsp_open;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= mode_type'(req_mode);
         s1_x_ff    <= req_x_coord;
         s1_y_ff    <= req_y_coord;
         s1_z_ff    <= req_z_coord;
         s1_slab_ff <= req_slab_index;
         s1_olo_ff  <= req_other_low;
         s1_ohi_ff  <= req_other_high;
      end
   end

   // Project the point onto the nine slab directions.
   logic signed [SLAB_BITS-1:0] px;
   logic signed [SLAB_BITS-1:0] py;
   logic signed [SLAB_BITS-1:0] pz;
   logic signed [SLAB_BITS-1:0] proj [SLAB_COUNT];

   assign px = {{2{s1_x_ff[COORD_BITS-1]}}, s1_x_ff};
   assign py = {{2{s1_y_ff[COORD_BITS-1]}}, s1_y_ff};
   assign pz = {{2{s1_z_ff[COORD_BITS-1]}}, s1_z_ff};

   assign proj[0] = px;
   assign proj[1] = py;
   assign proj[2] = pz;
   assign proj[3] = px + py;
   assign proj[4] = px + pz;
   assign proj[5] = py + pz;
   assign proj[6] = px - py;
   assign proj[7] = px - pz;
   assign proj[8] = py - pz;

   // The slab registers only change when the command moves on to the response stage.
   cmd_type cmd;
   assign cmd = '{mode: s1_mode_ff, write_en: s1_fire};

   logic signed [SLAB_BITS-1:0] cell_low       [SLAB_COUNT];
   logic signed [SLAB_BITS-1:0] cell_high      [SLAB_COUNT];
   logic signed [SLAB_BITS-1:0] cell_low_next  [SLAB_COUNT];
   logic signed [SLAB_BITS-1:0] cell_high_next [SLAB_COUNT];
   logic [SLAB_COUNT-1:0]       cell_inside;
   logic [SLAB_COUNT-1:0]       cell_sel;

   for (genvar g = 0; g < SLAB_COUNT; g++) begin : gen_slab
      assign cell_sel[g] = (s1_slab_ff == SLAB_IDX_BITS'(g));

      kdop_slab #(
         .SLAB_BITS (SLAB_BITS)
      ) u_slab (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sel        (cell_sel[g]),
         .proj       (proj[g]),
         .other_low  (s1_olo_ff),
         .other_high (s1_ohi_ff),
         .low_q      (cell_low[g]),
         .high_q     (cell_high[g]),
         .low_next   (cell_low_next[g]),
         .high_next  (cell_high_next[g]),
         .in_range   (cell_inside[g])
      );
   end

   // Pick the addressed slab; an index past the last slab selects nothing.
   logic                        slab_ok;
   logic signed [SLAB_BITS-1:0] sel_low;
   logic signed [SLAB_BITS-1:0] sel_high;
   logic signed [SLAB_BITS-1:0] sel_low_next;
   logic signed [SLAB_BITS-1:0] sel_high_next;

   assign slab_ok = (s1_slab_ff < SLAB_IDX_BITS'(SLAB_COUNT));

   always_comb begin
      sel_low       = '0;
      sel_high      = '0;
      sel_low_next  = '0;
      sel_high_next = '0;
      for (int i = 0; i < SLAB_COUNT; i++) begin
         if (cell_sel[i]) begin
            sel_low       = cell_low[i];
            sel_high      = cell_high[i];
            sel_low_next  = cell_low_next[i];
            sel_high_next = cell_high_next[i];
         end
      end
   end

   // Response formation. Commands that only change the volume answer with zeros.
   always_comb begin
      rsp_flag_in = 1'b0;
      rsp_low_in  = '0;
      rsp_high_in = '0;
      unique case (s1_mode_ff)
         MODE_INSIDE: begin
            rsp_flag_in = &cell_inside;
         end
         MODE_READ: begin
            if (slab_ok) begin
               rsp_low_in  = sel_low;
               rsp_high_in = sel_high;
            end
         end
         MODE_INTERSECT: begin
            if (slab_ok && (sel_low <= s1_ohi_ff) && (sel_high >= s1_olo_ff)) begin
               rsp_flag_in = 1'b1;
               rsp_low_in  = (sel_low > s1_olo_ff) ? sel_low : s1_olo_ff;
               rsp_high_in = (sel_high < s1_ohi_ff) ? sel_high : s1_ohi_ff;
            end
         end
         MODE_MERGE: begin
            // Merge answers with the slab as it stands after the merge.
            if (slab_ok) begin
               rsp_low_in  = sel_low_next;
               rsp_high_in = sel_high_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_flag_ff <= rsp_flag_in;
         rsp_low_ff  <= rsp_low_in;
         rsp_high_ff <= rsp_high_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_flag        = rsp_flag_ff;
   assign rsp_result_low  = rsp_low_ff;
   assign rsp_result_high = rsp_high_ff;

endmodule

`default_nettype wire

### rtl/kdop_slab.sv
`default_nettype none

module kdop_slab #(
   parameter int SLAB_BITS = kdop_pkg::COORD_BITS_DEFAULT + 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire kdop_pkg::cmd_type           cmd,
   input  wire logic                        sel,
   input  wire logic signed [SLAB_BITS-1:0] proj,
   input  wire logic signed [SLAB_BITS-1:0] other_low,
   input  wire logic signed [SLAB_BITS-1:0] other_high,
   output logic signed [SLAB_BITS-1:0]      low_q,
   output logic signed [SLAB_BITS-1:0]      high_q,
   output logic signed [SLAB_BITS-1:0]      low_next,
   output logic signed [SLAB_BITS-1:0]      high_next,
   output logic                             in_range
);
   import kdop_pkg::*;

   // Empty marker: low at the largest value, high at the smallest.
   localparam logic signed [SLAB_BITS-1:0] SLAB_MAX = {1'b0, {(SLAB_BITS-1){1'b1}}};
   localparam logic signed [SLAB_BITS-1:0] SLAB_MIN = {1'b1, {(SLAB_BITS-1){1'b0}}};

   logic signed [SLAB_BITS-1:0] low_ff;
   logic signed [SLAB_BITS-1:0] high_ff;
   logic signed [SLAB_BITS-1:0] low_in;
   logic signed [SLAB_BITS-1:0] high_in;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.write_en) begin
         unique case (cmd.mode)
            MODE_CLEAR: begin
               low_in  = SLAB_MAX;
               high_in = SLAB_MIN;
            end
            MODE_ADD: begin
               if (proj < low_ff) low_in = proj;
               if (proj > high_ff) high_in = proj;
            end
            MODE_SET: begin
               low_in  = proj;
               high_in = proj;
            end
            MODE_MERGE: begin
               if (sel && (other_low < low_ff)) low_in = other_low;
               if (sel && (other_high > high_ff)) high_in = other_high;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= SLAB_MAX;
         high_ff <= SLAB_MIN;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign low_q     = low_ff;
   assign high_q    = high_ff;
   assign low_next  = low_in;
   assign high_next = high_in;
   assign in_range  = (proj >= low_ff) && (proj <= high_ff);

endmodule

`default_nettype wire
